@@ design/lssc_pkg.sv @@
`default_nettype none

package lssc_pkg;

	// sizes of the count and millisecond timer
	localparam int COUNT_WIDTH = 16;
	localparam int TIMER_WIDTH = 16;

	localparam int HOLD_WIDTH  = 16;
	localparam int VALUE_WIDTH = 16;
	localparam int DELTA_WIDTH = 8;
	localparam int CARS_WIDTH  = 16;

	localparam int IN_BYTES  = 4;
	localparam int OUT_BYTES = 3;

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
	localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = '1;
	localparam logic [HOLD_WIDTH-1:0]  HOLD_RESET = 16'd2000;
	localparam logic [DELTA_WIDTH-1:0] DELTA_MINUS_ONE = '1;

	// action codes
	localparam logic [2:0] ACT_REQUEST = 3'd0;
	localparam logic [2:0] ACT_SET     = 3'd1;
	localparam logic [2:0] ACT_DELTA   = 3'd2;
	localparam logic [2:0] ACT_EVAL    = 3'd3;
	localparam logic [2:0] ACT_TICK    = 3'd4;

	// lane modes
	localparam logic [2:0] MODE_STOP_DET   = 3'd0;
	localparam logic [2:0] MODE_STOP_EMPTY = 3'd1;
	localparam logic [2:0] MODE_STOP_WAIT  = 3'd2;
	localparam logic [2:0] MODE_FLOW_DET   = 3'd3;
	localparam logic [2:0] MODE_FLOW_EMPTY = 3'd4;
	localparam logic [2:0] MODE_FLOWING    = 3'd5;

	// lamp colours
	localparam logic [1:0] LAMP_RED    = 2'd0;
	localparam logic [1:0] LAMP_ORANGE = 2'd1;
	localparam logic [1:0] LAMP_GREEN  = 2'd2;

endpackage

`default_nettype wire

@@ design/lane_signal_state_controller_unit.sv @@
`default_nettype none
// An accepted input beat is registered in stage 1, then its result in stage 2, which drives m_tdata.
// Throughput: one beat per cycle, sustained, as long as m_tready stays high.
// The state update of each beat is registered together with its result, so beats may follow back to back.
// Reset (arst_n low, asynchronous): lane stop-determine, lamp red, count and timer zero,
// nothing pending, hold time 2000; both pipeline stages emptied.

module lane_signal_state_controller_unit
	import lssc_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// hold-time register write
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [HOLD_WIDTH-1:0]  cfg_data,
	// input stream
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// [2:0] action, [5:3] target_state, [21:6] count_value, [29:22] count_delta, [31:30] zero
	input  wire logic [8*IN_BYTES-1:0]  s_tdata,
	// result stream
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// [2:0] lane_mode, [4:3] lamp_colour, [20:5] cars_present, [21] change_pending,
	// [23:22] zero
	output logic [8*OUT_BYTES-1:0]      m_tdata
);

	// ---------------------------------------------------------------
	// Input register (stage 1)
	// ---------------------------------------------------------------
	logic                          valid_s1;
	logic [2:0]                    action_s1;
	logic [2:0]                    target_s1;
	logic [VALUE_WIDTH-1:0]        value_s1;
	logic signed [DELTA_WIDTH-1:0] delta_s1;

	// Result register (stage 2)
	logic                          valid_s2;
	logic [2:0]                    mode_s2;
	logic [1:0]                    lamp_s2;
	logic [CARS_WIDTH-1:0]         cars_s2;
	logic                          pend_s2;

	// Lane state
	logic [HOLD_WIDTH-1:0]  hold_q;
	logic [2:0]             mode_q;
	logic [COUNT_WIDTH-1:0] cars_q;
	logic                   pending_q;
	logic                   green_q;
	logic [TIMER_WIDTH-1:0] elapsed_q;
	logic [1:0]             lamp_q;

	logic adv;    // stage 2 can take a new beat
	logic step;   // a stage 1 beat is processed this cycle

	assign adv       = !valid_s2 || m_tready;
	assign s_tready  = !valid_s1 || adv;
	assign step      = valid_s1 && adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			action_s1 <= s_tdata[2:0];
			target_s1 <= s_tdata[5:3];
			value_s1  <= s_tdata[21:6];
			delta_s1  <= s_tdata[29:22];
		end
	end

	// ---------------------------------------------------------------
	// Next-state logic
	// ---------------------------------------------------------------

	// set count: saturate the 16-bit value at the count maximum
	logic [32:0]            set_wide;
	logic [COUNT_WIDTH-1:0] set_cnt;
	assign set_wide = 33'(value_s1);
	assign set_cnt  = (set_wide > 33'(COUNT_MAX)) ? COUNT_MAX : COUNT_WIDTH'(set_wide);

	// count delta: signed sum clamped to [0, max]
	logic signed [33:0]     sum_wide;
	logic [COUNT_WIDTH-1:0] delta_cnt;
	logic                   delta_skip;
	assign sum_wide   = $signed({2'b00, 32'(cars_q)}) + 34'(delta_s1);
	assign delta_cnt  = (sum_wide < 0) ? '0 :
		(sum_wide > $signed({2'b00, 32'(COUNT_MAX)})) ? COUNT_MAX :
		COUNT_WIDTH'(sum_wide);
	// minus one at an empty count is dropped altogether
	assign delta_skip = (cars_q == '0) && (delta_s1 == DELTA_MINUS_ONE);

	// determine modes resolve from the count on evaluate
	logic [2:0] mode_res;
	always_comb begin
		mode_res = mode_q;
		if (mode_q == MODE_STOP_DET) begin
			mode_res = (cars_q == '0) ? MODE_STOP_EMPTY : MODE_STOP_WAIT;
		end else if (mode_q == MODE_FLOW_DET) begin
			mode_res = (cars_q == '0) ? MODE_FLOW_EMPTY : MODE_FLOWING;
		end
	end

	logic                   hold_over;
	assign hold_over = 32'(elapsed_q) > 32'(hold_q);

	logic [2:0]             mode_n;
	logic [COUNT_WIDTH-1:0] cars_n;
	logic                   pending_n;
	logic                   green_n;
	logic [TIMER_WIDTH-1:0] elapsed_n;
	logic [1:0]             lamp_n;
	logic                   req_take;
	logic [2:0]             req_tgt;

	always_comb begin
		mode_n    = mode_q;
		cars_n    = cars_q;
		pending_n = pending_q;
		green_n   = green_q;
		elapsed_n = elapsed_q;
		lamp_n    = lamp_q;
		req_take  = 1'b0;
		req_tgt   = target_s1;
		case (action_s1)
			ACT_REQUEST: begin
				req_take = 1'b1;
			end
			ACT_SET: begin
				cars_n = set_cnt;
			end
			ACT_DELTA: begin
				if (!delta_skip) begin
					cars_n = delta_cnt;
					// any count delta that is not dropped asks for flowing while the lane is flow-empty
					if (mode_q == MODE_FLOW_EMPTY) begin
						req_take = 1'b1;
						req_tgt  = MODE_FLOWING;
					end
				end
			end
			ACT_EVAL: begin
				if (pending_q) begin
					mode_n = mode_res;
					if (mode_res == MODE_FLOWING) begin
						lamp_n    = LAMP_GREEN;
						pending_n = 1'b0;
						green_n   = 1'b1;
					end else if (mode_res == MODE_FLOW_EMPTY || mode_res == MODE_STOP_WAIT ||
							mode_res == MODE_STOP_EMPTY) begin
						if (green_q) begin
							lamp_n  = LAMP_ORANGE;
							green_n = 1'b0;
						end
						if (hold_over) begin
							lamp_n    = LAMP_RED;
							pending_n = 1'b0;
						end
					end
				end
			end
			ACT_TICK: begin
				if (elapsed_q != TIMER_MAX) begin
					elapsed_n = elapsed_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
		// a request is only taken with nothing pending; unknown targets keep the mode
		if (req_take && !pending_q) begin
			if (req_tgt <= MODE_FLOWING) begin
				mode_n = req_tgt;
			end
			elapsed_n = '0;
			pending_n = 1'b1;
		end
	end

	// ---------------------------------------------------------------
	// State and result registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q    <= HOLD_RESET;
			mode_q    <= MODE_STOP_DET;
			cars_q    <= '0;
			pending_q <= 1'b0;
			green_q   <= 1'b0;
			elapsed_q <= '0;
			lamp_q    <= LAMP_RED;
			valid_s2  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				hold_q <= cfg_data;
			end
			if (step) begin
				mode_q    <= mode_n;
				cars_q    <= cars_n;
				pending_q <= pending_n;
				green_q   <= green_n;
				elapsed_q <= elapsed_n;
				lamp_q    <= lamp_n;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			mode_s2 <= mode_n;
			lamp_s2 <= lamp_n;
			cars_s2 <= CARS_WIDTH'(cars_n);
			pend_s2 <= pending_n;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {2'b00, pend_s2, cars_s2, lamp_s2, mode_s2};

`ifndef ASSERT_OFF
	// the was-green mark only lives while green is shown
	a_green_mark: assert property (@(posedge clk) disable iff (!arst_n)
		green_q |-> lamp_q == LAMP_GREEN)
		else $error("was-green set without green lamp");

	// green shown outside flowing only while a change is still pending
	a_green_mode: assert property (@(posedge clk) disable iff (!arst_n)
		lamp_q == LAMP_GREEN |-> (mode_q == MODE_FLOWING || pending_q))
		else $error("green lamp with settled non-flowing mode");

	// a taken request restarts the timer and marks the change pending
	a_req_taken: assert property (@(posedge clk) disable iff (!arst_n)
		step && action_s1 == ACT_REQUEST && !pending_q |=> elapsed_q == '0 && pending_q)
		else $error("request not taken");

	// every processed beat lands in the result register
	a_stage_move: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> valid_s2)
		else $error("processed beat lost");
`endif

endmodule

`default_nettype wire
